FILE: rtl/core/usrh_pkg.sv
package usrh_pkg;

  localparam int NUM_ENDPOINTS = 16;
  localparam int EP_SLOTS      = 16;
  localparam int EP_W          = 4;

  typedef enum logic [1:0] {
    ST_ACK   = 2'd0,
    ST_STALL = 2'd1,
    ST_CLASS = 2'd2,
    ST_DESC  = 2'd3
  } status_t;

  localparam logic [7:0] RQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] RQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] RQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] RQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] RQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] RQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] RQ_SET_INTERFACE     = 8'd11;

  localparam logic [4:0]  RECIP_ENDPOINT  = 5'd2;
  localparam logic [1:0]  TYPE_STANDARD   = 2'd0;
  localparam logic [15:0] FEATURE_EP_HALT = 16'd0;
  localparam logic [7:0]  CFG_COUNT_RESET = 8'd1;

  typedef struct packed {
    logic            cmd;
    logic [7:0]      request_type;
    logic [7:0]      request_code;
    logic [15:0]     request_value;
    logic [15:0]     request_index;
    logic [15:0]     request_length;
    logic [EP_W-1:0] halt_endpoint;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  reply_len;
    logic [15:0] reply_data;
    logic [6:0]  device_address;
    logic [7:0]  active_configuration;
  } result_t;

  typedef struct packed {
    logic [6:0]          address;
    logic [7:0]          configuration;
    logic [EP_SLOTS-1:0] halt;
    logic [7:0]          configuration_count;
  } dev_state_t;

  function automatic logic ep_exists(input logic [EP_W-1:0] ep);
    return {1'b0, ep} < (EP_W + 1)'(NUM_ENDPOINTS);
  endfunction

endpackage

FILE: rtl/core/usb_standard_request_handler_core.sv
// A transaction is held in the input register and decoded combinationally into the result
// register, which drives the output until the sink takes it.
// Throughput: one transaction per cycle while the sink does not stall; each of the input
// and result registers is released as soon as the next stage can take its content.
// Reset (rst_n low at a clock edge) clears the address, configuration and halt
// bits, sets the configuration count to one and empties both registers.
module usb_standard_request_handler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // request_type, request_code, request_value,
                                  // request_index, request_length, halt_endpoint, zero pad
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // reply_len, reply_data, device_address,
                                  // active_configuration, zero pad
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  usrh_pkg::item_t      s1_item_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  usrh_pkg::result_t    out_res_r;
  usrh_pkg::result_t    res;
  usrh_pkg::dev_state_t cur;
  usrh_pkg::dev_state_t nxt;
  usrh_pkg::item_t      in_item;
  logic                 advance;
  logic                 in_take;

  assign in_item.cmd            = in_tuser;
  assign in_item.request_type   = in_tdata[7:0];
  assign in_item.request_code   = in_tdata[15:8];
  assign in_item.request_value  = in_tdata[31:16];
  assign in_item.request_index  = in_tdata[47:32];
  assign in_item.request_length = in_tdata[63:48];
  assign in_item.halt_endpoint  = in_tdata[67:64];

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = in_take || (s1_valid_r && !advance);
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  usrh_decode u_decode (
    .item (s1_item_r),
    .cur  (cur),
    .res  (res),
    .nxt  (nxt)
  );

  usrh_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .upd_en      (advance),
    .upd         (nxt),
    .cur         (cur)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {7'd0, out_res_r.active_configuration, out_res_r.device_address,
                       out_res_r.reply_data, out_res_r.reply_len};

endmodule

FILE: rtl/core/usrh_decode.sv
module usrh_decode (
  input  usrh_pkg::item_t      item,
  input  usrh_pkg::dev_state_t cur,
  output usrh_pkg::result_t    res,
  output usrh_pkg::dev_state_t nxt
);

  usrh_pkg::status_t           status;
  logic [1:0]                  nat_len;
  logic [15:0]                 nat_data;
  logic [1:0]                  len;
  logic [15:0]                 data;
  logic                        dev2host;
  logic [4:0]                  recip;
  logic [usrh_pkg::EP_W-1:0]   ep;

  assign dev2host = item.request_type[7];
  assign recip    = item.request_type[4:0];
  assign ep       = item.request_index[usrh_pkg::EP_W-1:0];

  always_comb begin
    status   = usrh_pkg::ST_STALL;
    nat_len  = 2'd0;
    nat_data = 16'd0;
    nxt      = cur;
    if (item.cmd) begin
      status = usrh_pkg::ST_ACK;
      if (usrh_pkg::ep_exists(item.halt_endpoint)) begin
        nxt.halt[item.halt_endpoint] = 1'b1;
      end
    end else if (item.request_type[6:5] != usrh_pkg::TYPE_STANDARD) begin
      status = usrh_pkg::ST_CLASS;
    end else begin
      unique case (item.request_code)
        usrh_pkg::RQ_GET_DESCRIPTOR: begin
          if (dev2host) status = usrh_pkg::ST_DESC;
        end
        usrh_pkg::RQ_SET_ADDRESS: begin
          if (!dev2host && item.request_value[15:7] == 9'd0) begin
            nxt.address = item.request_value[6:0];
            status      = usrh_pkg::ST_ACK;
          end
        end
        usrh_pkg::RQ_SET_CONFIGURATION: begin
          if (!dev2host && item.request_value <= {8'd0, cur.configuration_count}) begin
            nxt.configuration = item.request_value[7:0];
            status            = usrh_pkg::ST_ACK;
          end
        end
        usrh_pkg::RQ_GET_CONFIGURATION: begin
          if (dev2host) begin
            status   = usrh_pkg::ST_ACK;
            nat_len  = 2'd1;
            nat_data = {8'd0, cur.configuration};
          end
        end
        usrh_pkg::RQ_GET_STATUS: begin
          if (dev2host) begin
            status  = usrh_pkg::ST_ACK;
            nat_len = 2'd2;
            if (recip == usrh_pkg::RECIP_ENDPOINT && usrh_pkg::ep_exists(ep)) begin
              nat_data = {15'd0, cur.halt[ep]};
            end
          end
        end
        usrh_pkg::RQ_CLEAR_FEATURE: begin
          if (!dev2host && recip == usrh_pkg::RECIP_ENDPOINT &&
              item.request_value == usrh_pkg::FEATURE_EP_HALT) begin
            if (usrh_pkg::ep_exists(ep)) begin
              nxt.halt[ep] = 1'b0;
            end
            status = usrh_pkg::ST_ACK;
          end
        end
        usrh_pkg::RQ_GET_INTERFACE: begin
          if (dev2host) begin
            status  = usrh_pkg::ST_ACK;
            nat_len = 2'd1;
          end
        end
        usrh_pkg::RQ_SET_INTERFACE: begin
          if (!dev2host && item.request_value == 16'd0) status = usrh_pkg::ST_ACK;
        end
        default: begin
          status = usrh_pkg::ST_STALL;
        end
      endcase
    end

    if (item.request_length < {14'd0, nat_len}) begin
      len = item.request_length[1:0];
    end else begin
      len = nat_len;
    end

    unique case (len)
      2'd0:    data = 16'd0;
      2'd1:    data = {8'd0, nat_data[7:0]};
      default: data = nat_data;
    endcase

    res.status               = status;
    res.reply_len            = len;
    res.reply_data           = data;
    res.device_address       = nxt.address;
    res.active_configuration = nxt.configuration;
  end

endmodule

FILE: rtl/core/usrh_state.sv
module usrh_state (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 upd_en,
  input  usrh_pkg::dev_state_t upd,
  output usrh_pkg::dev_state_t cur
);

  logic [6:0]                    address_r;
  logic [7:0]                    configuration_r;
  logic [usrh_pkg::EP_SLOTS-1:0] halt_r;
  logic [7:0]                    cfg_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_r       <= 7'd0;
      configuration_r <= 8'd0;
      halt_r          <= '0;
      cfg_count_r     <= usrh_pkg::CFG_COUNT_RESET;
    end else begin
      if (upd_en) begin
        address_r       <= upd.address;
        configuration_r <= upd.configuration;
        halt_r          <= upd.halt;
      end
      if (cfg_wr_en) begin
        cfg_count_r <= cfg_wr_data;
      end
    end
  end

  assign cur.address             = address_r;
  assign cur.configuration       = configuration_r;
  assign cur.halt                = halt_r;
  assign cur.configuration_count = cfg_count_r;

endmodule

FILE: rtl/core/usrh_checker.sv
module usrh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A held result must not change while the sink stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // The input side only backs up when a result is waiting and stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // A data stage is only reported for an acknowledged request.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tuser == usrh_pkg::ST_ACK)
    else $error("reply data on a non-ack result");

  // A one-byte reply carries nothing in its upper byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd2 |-> out_tdata[17:10] == 8'd0)
    else $error("reply bytes beyond the reply length");

  // Reset empties the result register.
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind usb_standard_request_handler_core usrh_checker u_usrh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: verif/tb_usb_standard_request_handler_core.sv
`timescale 1ns / 100ps

import usrh_pkg::*;

class device_request_scoreboard;

  result_t        expected_replies[$];
  logic [6:0]     address;
  logic [7:0]     configuration;
  logic [15:0]    halted;
  logic [7:0]     config_count;
  int             errors;

  function new();
    address       = '0;
    configuration = '0;
    halted        = '0;
    config_count  = CFG_COUNT_RESET;
    errors        = 0;
  endfunction

  function void set_config_count(logic [7:0] value);
    config_count = value;
  endfunction

  function int pending();
    return expected_replies.size();
  endfunction

  function void accept_request(item_t it);
    result_t    r;
    logic       dev2host;
    logic [4:0] recip;
    logic [3:0] ep;
    dev2host = it.request_type[7];
    recip    = it.request_type[4:0];
    ep       = it.request_index[3:0];
    r        = '0;
    r.status = ST_STALL;
    if (it.cmd) begin
      if (int'(it.halt_endpoint) < NUM_ENDPOINTS) halted[it.halt_endpoint] = 1'b1;
      r.status = ST_ACK;
    end else if (it.request_type[6:5] != TYPE_STANDARD) begin
      r.status = ST_CLASS;
    end else begin
      case (it.request_code)
        RQ_GET_DESCRIPTOR: begin
          if (dev2host) r.status = ST_DESC;
        end
        RQ_SET_ADDRESS: begin
          if (!dev2host && it.request_value <= 16'd127) begin
            address  = it.request_value[6:0];
            r.status = ST_ACK;
          end
        end
        RQ_SET_CONFIGURATION: begin
          if (!dev2host && it.request_value <= {8'd0, config_count}) begin
            configuration = it.request_value[7:0];
            r.status      = ST_ACK;
          end
        end
        RQ_GET_CONFIGURATION: begin
          if (dev2host) begin
            r.status     = ST_ACK;
            r.reply_len  = 2'd1;
            r.reply_data = {8'd0, configuration};
          end
        end
        RQ_GET_STATUS: begin
          if (dev2host) begin
            r.status    = ST_ACK;
            r.reply_len = 2'd2;
            if (recip == RECIP_ENDPOINT && int'(ep) < NUM_ENDPOINTS)
              r.reply_data = {15'd0, halted[ep]};
          end
        end
        RQ_CLEAR_FEATURE: begin
          if (!dev2host && recip == RECIP_ENDPOINT && it.request_value == FEATURE_EP_HALT) begin
            if (int'(ep) < NUM_ENDPOINTS) halted[ep] = 1'b0;
            r.status = ST_ACK;
          end
        end
        RQ_GET_INTERFACE: begin
          if (dev2host) begin
            r.status    = ST_ACK;
            r.reply_len = 2'd1;
          end
        end
        RQ_SET_INTERFACE: begin
          if (!dev2host && it.request_value == 16'd0) r.status = ST_ACK;
        end
        default: begin
        end
      endcase
      if (r.status != ST_ACK) begin
        r.reply_len  = '0;
        r.reply_data = '0;
      end
      if (r.reply_len > it.request_length) r.reply_len = it.request_length[1:0];
      if (r.reply_len == 2'd0) begin
        r.reply_data = '0;
      end else if (r.reply_len == 2'd1) begin
        r.reply_data[15:8] = '0;
      end
    end
    r.device_address       = address;
    r.active_configuration = configuration;
    expected_replies.push_back(r);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_reply(logic [1:0] status_bits, logic [39:0] data_bits);
    result_t want;
    result_t got;
    got = {status_bits, data_bits[1:0], data_bits[17:2], data_bits[24:18], data_bits[32:25]};
    if (expected_replies.size() == 0) begin
      $display("%0t: unexpected reply, expected none actual status %0d data %h",
               $time, status_bits, data_bits);
      errors++;
      return;
    end
    want = expected_replies.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("reply_len", want.reply_len, got.reply_len);
    compare_field("reply_data", want.reply_data, got.reply_data);
    compare_field("device_address", want.device_address, got.device_address);
    compare_field("active_configuration", want.active_configuration,
                  got.active_configuration);
  endfunction
endclass

module tb_usb_standard_request_handler_core;
  import usrh_pkg::*;

  localparam int         CYCLE_LIMIT    = 400000;
  localparam int         PHASE_ITEMS    = 242;
  localparam logic [7:0] DIR_IN         = 8'h80;
  localparam logic [7:0] TYPE_CLASS     = 8'h20;
  localparam logic [7:0] TYPE_VENDOR    = 8'h40;
  localparam logic [7:0] TYPE_RESERVED  = 8'h60;
  localparam logic [7:0] TO_DEVICE      = 8'h00;
  localparam logic [7:0] TO_INTERFACE   = 8'h01;
  localparam logic [7:0] TO_ENDPOINT    = 8'h02;
  localparam logic [7:0] RQ_UNKNOWN     = 8'hFF;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata    = '0;
  logic        in_tuser    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  int sender_idle    = 0;
  int receiver_stall = 0;
  int cycles         = 0;

  device_request_scoreboard sb = new();

  usb_standard_request_handler_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_usb_standard_request_handler_core: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tuser, out_tdata);
    out_tready <= ($urandom_range(99) >= receiver_stall);
  end

  function automatic item_t setup_packet(logic [7:0] rtype, logic [7:0] code,
                                         logic [15:0] value, logic [15:0] index,
                                         logic [15:0] length);
    item_t it;
    it.cmd            = 1'b0;
    it.request_type   = rtype;
    it.request_code   = code;
    it.request_value  = value;
    it.request_index  = index;
    it.request_length = length;
    it.halt_endpoint  = 4'($urandom_range(15));
    return it;
  endfunction

  function automatic item_t halt_event(logic [3:0] ep);
    item_t it;
    it               = setup_packet(8'($urandom_range(255)), 8'($urandom_range(255)),
                                    16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                    16'($urandom_range(65535)));
    it.cmd           = 1'b1;
    it.halt_endpoint = ep;
    return it;
  endfunction

  function automatic item_t random_request(logic [7:0] count_limit);
    item_t      it;
    int         pick;
    logic       dev2host;
    logic [7:0] code;
    logic [7:0] rtype;
    logic [15:0] value;
    logic [15:0] length;
    pick = $urandom_range(99);
    it   = halt_event(4'($urandom_range(15)));
    if (pick < 12) return it;
    it.cmd = 1'b0;
    if (pick < 22) return it;
    case ($urandom_range(8))
      0: code = RQ_GET_STATUS;
      1: code = RQ_CLEAR_FEATURE;
      2: code = RQ_SET_ADDRESS;
      3: code = RQ_GET_DESCRIPTOR;
      4: code = RQ_GET_CONFIGURATION;
      5: code = RQ_SET_CONFIGURATION;
      6: code = RQ_GET_INTERFACE;
      7: code = RQ_SET_INTERFACE;
      default: code = 8'($urandom_range(255));
    endcase
    dev2host = (code == RQ_GET_STATUS || code == RQ_GET_DESCRIPTOR ||
                code == RQ_GET_CONFIGURATION || code == RQ_GET_INTERFACE);
    if ($urandom_range(9) == 0) dev2host = !dev2host;
    case ($urandom_range(3))
      0: rtype = TO_DEVICE;
      1: rtype = TO_INTERFACE;
      2: rtype = TO_ENDPOINT;
      default: rtype = 8'($urandom_range(31));
    endcase
    if (dev2host) rtype = rtype | DIR_IN;
    if ($urandom_range(9) == 0) rtype[6:5] = 2'($urandom_range(3));
    value = 16'($urandom_range(65535));
    if ($urandom_range(99) < 85) begin
      if (code == RQ_SET_ADDRESS) value = 16'($urandom_range(127));
      if (code == RQ_SET_CONFIGURATION) value = 16'($urandom_range(int'(count_limit) + 1));
      if (code == RQ_CLEAR_FEATURE || code == RQ_SET_INTERFACE) value = FEATURE_EP_HALT;
    end
    case ($urandom_range(3))
      0: length = 16'd0;
      1: length = 16'd1;
      2: length = 16'd2;
      default: length = 16'($urandom_range(65535));
    endcase
    it.request_type   = rtype;
    it.request_code   = code;
    it.request_value  = value;
    it.request_length = length;
    if ($urandom_range(9) < 7) it.request_index = 16'($urandom_range(15));
    return it;
  endfunction

  task automatic send_request(input item_t it);
    while ($urandom_range(99) < sender_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {4'd0, it.halt_endpoint, it.request_length, it.request_index,
                  it.request_value, it.request_code, it.request_type};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.accept_request(it);
  endtask

  task automatic wait_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config_count(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_config_count(value);
  endtask

  task automatic run_phase(input logic [7:0] count_limit, input int idle, input int stall,
                           input bit pause_midway);
    wait_replies();
    sender_idle    = idle;
    receiver_stall = stall;
    write_config_count(count_limit);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (pause_midway && i == PHASE_ITEMS / 2) wait_replies();
      send_request(random_request(count_limit));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The configuration count still holds its reset value here.
    send_request(halt_event(4'd0));
    send_request(halt_event(4'd15));
    send_request(setup_packet(DIR_IN | TO_ENDPOINT, RQ_GET_STATUS, 16'd0, 16'h000F, 16'd2));
    send_request(setup_packet(DIR_IN | TO_ENDPOINT, RQ_GET_STATUS, 16'd0, 16'hFFF0, 16'd1));
    send_request(setup_packet(DIR_IN | TO_ENDPOINT, RQ_GET_STATUS, 16'd0, 16'h0000, 16'd0));
    send_request(setup_packet(TO_ENDPOINT, RQ_CLEAR_FEATURE, FEATURE_EP_HALT, 16'hFFFF,
                              16'd0));
    send_request(setup_packet(DIR_IN | TO_ENDPOINT, RQ_GET_STATUS, 16'd0, 16'h000F,
                              16'hFFFF));
    send_request(setup_packet(DIR_IN | TO_DEVICE, RQ_GET_STATUS, 16'd0, 16'd0, 16'd2));
    send_request(setup_packet(DIR_IN | TO_INTERFACE, RQ_GET_STATUS, 16'd0, 16'd0, 16'd2));
    send_request(setup_packet(TO_ENDPOINT, RQ_CLEAR_FEATURE, 16'd1, 16'd0, 16'd0));
    send_request(setup_packet(TO_DEVICE, RQ_CLEAR_FEATURE, FEATURE_EP_HALT, 16'd0, 16'd0));
    send_request(setup_packet(TO_DEVICE, RQ_SET_ADDRESS, 16'd127, 16'd0, 16'd0));
    send_request(setup_packet(TO_DEVICE, RQ_SET_ADDRESS, 16'd128, 16'd0, 16'd0));
    send_request(setup_packet(DIR_IN | TO_DEVICE, RQ_SET_ADDRESS, 16'd3, 16'd0, 16'd0));
    send_request(setup_packet(TO_DEVICE, RQ_SET_CONFIGURATION, 16'd1, 16'd0, 16'd0));
    send_request(setup_packet(TO_DEVICE, RQ_SET_CONFIGURATION, 16'd2, 16'd0, 16'd0));
    send_request(setup_packet(DIR_IN | TO_DEVICE, RQ_GET_CONFIGURATION, 16'd0, 16'd0, 16'd1));
    send_request(setup_packet(DIR_IN | TO_DEVICE, RQ_GET_CONFIGURATION, 16'd0, 16'd0, 16'd0));
    send_request(setup_packet(DIR_IN | TO_DEVICE, RQ_GET_DESCRIPTOR, 16'h0100, 16'd0, 16'd18));
    send_request(setup_packet(TO_DEVICE, RQ_GET_DESCRIPTOR, 16'h0100, 16'd0, 16'd18));
    send_request(setup_packet(TYPE_CLASS | TO_INTERFACE, RQ_SET_CONFIGURATION, 16'd1, 16'd0,
                              16'd0));
    send_request(setup_packet(DIR_IN | TYPE_VENDOR, RQ_GET_STATUS, 16'd0, 16'd0, 16'd2));
    send_request(setup_packet(TYPE_RESERVED, RQ_SET_ADDRESS, 16'd9, 16'd0, 16'd0));
    send_request(setup_packet(DIR_IN | TO_INTERFACE, RQ_GET_INTERFACE, 16'd0, 16'd0, 16'd1));
    send_request(setup_packet(TO_INTERFACE, RQ_SET_INTERFACE, 16'd0, 16'd0, 16'd0));
    send_request(setup_packet(TO_INTERFACE, RQ_SET_INTERFACE, 16'd1, 16'd0, 16'd0));
    send_request(setup_packet(DIR_IN | TO_INTERFACE, RQ_SET_INTERFACE, 16'd0, 16'd0, 16'd0));
    send_request(setup_packet(TO_DEVICE, RQ_UNKNOWN, 16'd0, 16'd0, 16'd0));
    send_request(setup_packet(TO_DEVICE, RQ_SET_CONFIGURATION, 16'd0, 16'd0, 16'd0));

    run_phase(8'd0, 0, 0, 1'b0);
    run_phase(8'd255, 49, 0, 1'b1);
    run_phase(8'd3, 0, 49, 1'b0);
    run_phase(8'd1, 8, 8, 1'b0);
    run_phase(8'($urandom_range(255)), 49, 0, 1'b0);
    run_phase(8'($urandom_range(15)), 0, 0, 1'b0);

    wait_replies();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_usb_standard_request_handler_core: clean");
    end else begin
      $display("tb_usb_standard_request_handler_core: errors");
    end
    $finish;
  end
endmodule

FILE: usb_standard_request_handler_core.f
rtl/core/usrh_pkg.sv
rtl/core/usrh_decode.sv
rtl/core/usrh_state.sv
rtl/core/usb_standard_request_handler_core.sv
rtl/core/usrh_checker.sv
verif/tb_usb_standard_request_handler_core.sv
